>>> sv/bclh_pkg.sv
// ----------------------------------------------------------------------------
// bclh_pkg
// shared constants, command codes and status types of the block cache
// controller
// ----------------------------------------------------------------------------
package bclh_pkg;

    localparam int NUM_BUFFERS  = 32;
    localparam int HASH_ENTRIES = 64;
    localparam int BUF_AW       = $clog2(NUM_BUFFERS);
    localparam int HASH_AW      = $clog2(HASH_ENTRIES);
    localparam int DEV_W        = 3;
    localparam int SEC_W        = 32;
    localparam int SLOT_W       = 5;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 48;

    localparam logic [1:0] REQ_FETCH = 2'd0;
    localparam logic [1:0] REQ_DIRTY = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [SEC_W-1:0] sec;
    } t_tag;

    typedef struct packed {
        logic [BUF_AW-1:0] buf_id;
        logic [DEV_W-1:0]  dev;
        logic [SEC_W-1:0]  sec;
    } t_hent;

    localparam int TAG_W  = $bits(t_tag);
    localparam int HENT_W = $bits(t_hent);

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PROBE_NEXT,
        CMD_SET_B_LRU,
        CMD_SET_B_HASH,
        CMD_VIC_TAKE,
        CMD_SET_ERR,
        CMD_GAP_INIT,
        CMD_SHIFT,
        CMD_CLR_GAP,
        CMD_WR_TAG,
        CMD_ADD_WR,
        CMD_MRU,
        CMD_LRU_SCAN,
        CMD_OUT_HIT,
        CMD_OUT_MISS,
        CMD_OUT_FULL,
        CMD_OUT_MD,
        CMD_FL_NEXT,
        CMD_OUT_FL,
        CMD_OUT_FLDONE,
        CMD_OUT_BAD
    } t_cmd;

    typedef struct packed {
        logic used;
        logic match;
        logic cnt_last;
        logic vic_valid;
        logic fl_end;
        logic fl_dirty;
        logic out_free;
    } t_dp_status;

endpackage

>>> sv/bclh_ram.sv
// ----------------------------------------------------------------------------
// bclh_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bclh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bclh_datapath.sv
// ----------------------------------------------------------------------------
// bclh_datapath
// buffer flags, recency ranks, hash used bits, tag and hash rams, probe
// counters and the result register
// ----------------------------------------------------------------------------
module bclh_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bclh_pkg::t_cmd                 i_cmd,
    output bclh_pkg::t_dp_status           o_st,
    // device[2:0], block_sector[34:3], target_slot[39:35]
    input  logic [bclh_pkg::IN_DATA_W-1:0] i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // status[0], slot[5:1], hit[6], read_needed[7], writeback_needed[8],
    // wb_device[11:9], wb_sector[43:12]
    output logic [bclh_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);
    import bclh_pkg::*;

    logic [NUM_BUFFERS-1:0]  r_valid;
    logic [NUM_BUFFERS-1:0]  r_dirty;
    logic [BUF_AW-1:0]       r_rank [NUM_BUFFERS];
    logic [BUF_AW-1:0]       r_lru;
    logic [HASH_ENTRIES-1:0] r_used;

    logic [DEV_W-1:0]  r_new_dev;
    logic [SEC_W-1:0]  r_new_sec;
    logic [SLOT_W-1:0] r_tslot;
    logic [DEV_W-1:0]  r_key_dev;
    logic [SEC_W-1:0]  r_key_sec;
    logic [HASH_AW-1:0] r_idx;
    logic [HASH_AW-1:0] r_gap;
    logic [HASH_AW-1:0] r_cnt;
    logic [BUF_AW-1:0] r_b;
    logic [BUF_AW:0]   r_fi;
    logic              r_err;
    logic              r_wb;
    logic [DEV_W-1:0]  r_wdev;
    logic [SEC_W-1:0]  r_wsec;

    logic                  r_ovalid;
    logic                  r_olast;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [DEV_W-1:0]  w_in_dev;
    logic [SEC_W-1:0]  w_in_sec;
    logic [SLOT_W-1:0] w_in_slot;

    t_tag               w_tag_rd;
    t_hent              w_hent_rd;
    t_tag               w_tag_wr;
    t_hent              w_hent_wr;
    logic [TAG_W-1:0]   w_tag_rdata;
    logic [HENT_W-1:0]  w_hent_rdata;
    logic               w_hash_we;
    logic [HASH_AW-1:0] w_hash_waddr;
    logic [HASH_AW-1:0] w_home_k;
    logic               w_stays;
    logic [NUM_BUFFERS-1:0] w_rank0;
    logic [BUF_AW-1:0]  w_lru_next;
    logic               w_md_bad;
    logic [BUF_AW-1:0]  w_fi_b;
    logic [BUF_AW:0]    w_fi_inc;

    assign w_in_dev  = i_s_tdata[DEV_W-1:0];
    assign w_in_sec  = i_s_tdata[DEV_W+SEC_W-1:DEV_W];
    assign w_in_slot = i_s_tdata[DEV_W+SEC_W+SLOT_W-1:DEV_W+SEC_W];

    assign w_tag_rd  = t_tag'(w_tag_rdata);
    assign w_hent_rd = t_hent'(w_hent_rdata);
    assign w_tag_wr  = '{dev: r_new_dev, sec: r_new_sec};

    assign w_fi_b   = r_fi[BUF_AW-1:0];
    assign w_fi_inc = r_fi + 1'b1;

    bclh_ram #(.WIDTH(TAG_W), .DEPTH(NUM_BUFFERS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd == CMD_WR_TAG),
        .i_waddr (r_b),
        .i_wdata (w_tag_wr),
        .i_raddr (r_b),
        .o_rdata (w_tag_rdata)
    );

    always_comb begin
        w_hash_we    = 1'b0;
        w_hash_waddr = r_idx;
        w_hent_wr    = '{buf_id: r_b, dev: r_new_dev, sec: r_new_sec};
        if (i_cmd == CMD_ADD_WR) begin
            w_hash_we = 1'b1;
        end else if (i_cmd == CMD_SHIFT && !w_stays) begin
            w_hash_we    = 1'b1;
            w_hash_waddr = r_gap;
            w_hent_wr    = w_hent_rd;
        end
    end

    bclh_ram #(.WIDTH(HENT_W), .DEPTH(HASH_ENTRIES)) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (w_hash_we),
        .i_waddr (w_hash_waddr),
        .i_wdata (w_hent_wr),
        .i_raddr (r_idx),
        .o_rdata (w_hent_rdata)
    );

    // backward shift: does the entry at r_idx stay behind the gap
    assign w_home_k = w_hent_rd.sec[HASH_AW-1:0];
    always_comb begin
        if (r_gap <= r_idx) begin
            w_stays = (r_gap < w_home_k) && (w_home_k <= r_idx);
        end else begin
            w_stays = (w_home_k > r_gap) || (w_home_k <= r_idx);
        end
    end

    always_comb begin
        w_lru_next = '0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            w_rank0[i] = (r_rank[i] == '0);
            w_lru_next = w_lru_next | (BUF_AW'(i) & {BUF_AW{w_rank0[i]}});
        end
    end

    assign w_md_bad = ({1'b0, r_tslot} >= (SLOT_W+1)'(NUM_BUFFERS))
                   || !r_valid[BUF_AW'(r_tslot)];

    assign o_st.used      = r_used[r_idx];
    assign o_st.match     = (w_hent_rd.dev == r_key_dev) && (w_hent_rd.sec == r_key_sec);
    assign o_st.cnt_last  = (r_cnt == HASH_AW'(HASH_ENTRIES - 1));
    assign o_st.vic_valid = r_valid[r_b];
    assign o_st.fl_end    = (r_fi == (BUF_AW+1)'(NUM_BUFFERS)) || !r_valid[w_fi_b];
    assign o_st.fl_dirty  = r_dirty[w_fi_b];
    assign o_st.out_free  = !r_ovalid || i_m_tready;

    // control state: flags, ranks, lru pointer, used bits, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dirty  <= '0;
            r_used   <= '0;
            r_lru    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                r_rank[i] <= BUF_AW'(i);
            end
        end else begin
            unique case (i_cmd)
                CMD_VIC_TAKE: begin
                    r_valid[r_b] <= 1'b0;
                    r_dirty[r_b] <= 1'b0;
                end
                CMD_CLR_GAP: begin
                    r_used[r_gap] <= 1'b0;
                end
                CMD_ADD_WR: begin
                    r_used[r_idx] <= 1'b1;
                    r_valid[r_b]  <= 1'b1;
                    r_dirty[r_b]  <= 1'b0;
                end
                CMD_MRU: begin
                    for (int i = 0; i < NUM_BUFFERS; i++) begin
                        if (r_rank[i] > r_rank[r_b]) begin
                            r_rank[i] <= r_rank[i] - 1'b1;
                        end
                    end
                    r_rank[r_b] <= BUF_AW'(NUM_BUFFERS - 1);
                end
                CMD_LRU_SCAN: begin
                    r_lru <= w_lru_next;
                end
                CMD_OUT_MD: begin
                    if (!w_md_bad) begin
                        r_dirty[BUF_AW'(r_tslot)] <= 1'b1;
                    end
                end
                CMD_OUT_FL: begin
                    r_dirty[r_b] <= 1'b0;
                end
                default: begin
                end
            endcase
            if (i_cmd == CMD_OUT_HIT || i_cmd == CMD_OUT_MISS || i_cmd == CMD_OUT_FULL
                || i_cmd == CMD_OUT_MD || i_cmd == CMD_OUT_FL || i_cmd == CMD_OUT_FLDONE
                || i_cmd == CMD_OUT_BAD) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_new_dev <= w_in_dev;
                r_new_sec <= w_in_sec;
                r_tslot   <= w_in_slot;
                r_key_dev <= w_in_dev;
                r_key_sec <= w_in_sec;
                r_idx     <= w_in_sec[HASH_AW-1:0];
                r_cnt     <= '0;
                r_err     <= 1'b0;
                r_wb      <= 1'b0;
                r_wdev    <= '0;
                r_wsec    <= '0;
                r_fi      <= '0;
                r_b       <= '0;
            end
            CMD_PROBE_NEXT: begin
                r_idx <= r_idx + 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            CMD_SET_B_LRU: begin
                r_b <= r_lru;
            end
            CMD_SET_B_HASH: begin
                r_b <= w_hent_rd.buf_id;
            end
            CMD_VIC_TAKE: begin
                r_wb      <= r_dirty[r_b];
                r_wdev    <= r_dirty[r_b] ? w_tag_rd.dev : '0;
                r_wsec    <= r_dirty[r_b] ? w_tag_rd.sec : '0;
                r_key_dev <= w_tag_rd.dev;
                r_key_sec <= w_tag_rd.sec;
                r_idx     <= w_tag_rd.sec[HASH_AW-1:0];
                r_cnt     <= '0;
            end
            CMD_SET_ERR: begin
                r_err <= 1'b1;
            end
            CMD_GAP_INIT: begin
                r_gap <= r_idx;
                r_idx <= r_idx + 1'b1;
                r_cnt <= HASH_AW'(1);
            end
            CMD_SHIFT: begin
                if (!w_stays) begin
                    r_gap <= r_idx;
                end
                r_idx <= r_idx + 1'b1;
                r_cnt <= r_cnt + 1'b1;
            end
            CMD_WR_TAG: begin
                r_idx <= r_new_sec[HASH_AW-1:0];
                r_cnt <= '0;
            end
            CMD_FL_NEXT, CMD_OUT_FL: begin
                r_fi <= w_fi_inc;
                r_b  <= w_fi_inc[BUF_AW-1:0];
            end
            default: begin
            end
        endcase

        unique case (i_cmd)
            CMD_OUT_HIT: begin
                r_odata <= OUT_DATA_W'({1'b0, 1'b1, SLOT_W'(r_b), 1'b0});
                r_olast <= 1'b1;
            end
            CMD_OUT_MISS: begin
                r_odata <= OUT_DATA_W'({r_wsec, r_wdev, r_wb, 1'b1, 1'b0,
                                        SLOT_W'(r_b), r_err});
                r_olast <= 1'b1;
            end
            CMD_OUT_FULL: begin
                r_odata <= OUT_DATA_W'({r_wsec, r_wdev, r_wb, 1'b0, 1'b0,
                                        SLOT_W'(r_b), 1'b1});
                r_olast <= 1'b1;
            end
            CMD_OUT_MD: begin
                r_odata <= OUT_DATA_W'({r_tslot, w_md_bad});
                r_olast <= 1'b1;
            end
            CMD_OUT_FL: begin
                r_odata <= OUT_DATA_W'({w_tag_rd.sec, w_tag_rd.dev, 1'b1, 1'b0, 1'b0,
                                        SLOT_W'(r_b), 1'b0});
                r_olast <= 1'b0;
            end
            CMD_OUT_FLDONE: begin
                r_odata <= '0;
                r_olast <= 1'b1;
            end
            CMD_OUT_BAD: begin
                r_odata <= OUT_DATA_W'(1'b1);
                r_olast <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

`ifndef SYNTH
    a_rank_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_rank0))
        else $error("recency ranks lost their single oldest buffer");

    a_mru_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_MRU) |=> (r_rank[$past(r_b)] == BUF_AW'(NUM_BUFFERS - 1)))
        else $error("buffer not most recent after promotion");

    a_add_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_ADD_WR) |=> (r_used[$past(r_idx)] && r_valid[$past(r_b)]))
        else $error("insert did not mark entry and buffer");
`endif

endmodule

>>> sv/bclh_controller.sv
// ----------------------------------------------------------------------------
// bclh_controller
// request sequencer: lookup, eviction, backward shift delete, insert,
// mark dirty and flush scan
// ----------------------------------------------------------------------------
module bclh_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [1:0]           i_s_tuser,
    input  bclh_pkg::t_dp_status i_st,
    output bclh_pkg::t_cmd       o_cmd
);
    import bclh_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_RD,
        S_F_CHK,
        S_H_MRU,
        S_H_LRU,
        S_H_OUT,
        S_VIC_WAIT,
        S_VIC_CHK,
        S_R_RD,
        S_R_CHK,
        S_D_RD,
        S_D_CHK,
        S_D_END,
        S_WR_TAG,
        S_A_PROBE,
        S_M_MRU,
        S_M_LRU,
        S_M_OUT,
        S_FULL_OUT,
        S_MD_OUT,
        S_FL_CHK,
        S_FL_OUT,
        S_FL_DONE,
        S_BAD_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_s_tready;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && o_s_tready) begin
                    w_cmd = CMD_LOAD;
                    priority if (i_s_tuser == REQ_FETCH) begin
                        n_state = S_F_RD;
                    end else if (i_s_tuser == REQ_DIRTY) begin
                        n_state = S_MD_OUT;
                    end else if (i_s_tuser == REQ_FLUSH) begin
                        n_state = S_FL_CHK;
                    end else begin
                        n_state = S_BAD_OUT;
                    end
                end
            end
            S_F_RD: begin
                if (!i_st.used) begin
                    w_cmd   = CMD_SET_B_LRU;
                    n_state = S_VIC_WAIT;
                end else begin
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                priority if (i_st.match) begin
                    w_cmd   = CMD_SET_B_HASH;
                    n_state = S_H_MRU;
                end else if (i_st.cnt_last) begin
                    w_cmd   = CMD_SET_B_LRU;
                    n_state = S_VIC_WAIT;
                end else begin
                    w_cmd   = CMD_PROBE_NEXT;
                    n_state = S_F_RD;
                end
            end
            S_H_MRU: begin
                w_cmd   = CMD_MRU;
                n_state = S_H_LRU;
            end
            S_H_LRU: begin
                w_cmd   = CMD_LRU_SCAN;
                n_state = S_H_OUT;
            end
            S_H_OUT: begin
                if (i_st.out_free) begin
                    w_cmd   = CMD_OUT_HIT;
                    n_state = S_IDLE;
                end
            end
            S_VIC_WAIT: begin
                n_state = S_VIC_CHK;
            end
            S_VIC_CHK: begin
                if (i_st.vic_valid) begin
                    w_cmd   = CMD_VIC_TAKE;
                    n_state = S_R_RD;
                end else begin
                    n_state = S_WR_TAG;
                end
            end
            S_R_RD: begin
                if (!i_st.used) begin
                    w_cmd   = CMD_SET_ERR;
                    n_state = S_WR_TAG;
                end else begin
                    n_state = S_R_CHK;
                end
            end
            S_R_CHK: begin
                priority if (i_st.match) begin
                    w_cmd   = CMD_GAP_INIT;
                    n_state = S_D_RD;
                end else if (i_st.cnt_last) begin
                    w_cmd   = CMD_SET_ERR;
                    n_state = S_WR_TAG;
                end else begin
                    w_cmd   = CMD_PROBE_NEXT;
                    n_state = S_R_RD;
                end
            end
            S_D_RD: begin
                if (!i_st.used) begin
                    w_cmd   = CMD_CLR_GAP;
                    n_state = S_WR_TAG;
                end else begin
                    n_state = S_D_CHK;
                end
            end
            S_D_CHK: begin
                w_cmd   = CMD_SHIFT;
                n_state = i_st.cnt_last ? S_D_END : S_D_RD;
            end
            S_D_END: begin
                w_cmd   = CMD_CLR_GAP;
                n_state = S_WR_TAG;
            end
            S_WR_TAG: begin
                w_cmd   = CMD_WR_TAG;
                n_state = S_A_PROBE;
            end
            S_A_PROBE: begin
                priority if (!i_st.used) begin
                    w_cmd   = CMD_ADD_WR;
                    n_state = S_M_MRU;
                end else if (i_st.cnt_last) begin
                    n_state = S_FULL_OUT;
                end else begin
                    w_cmd = CMD_PROBE_NEXT;
                end
            end
            S_M_MRU: begin
                w_cmd   = CMD_MRU;
                n_state = S_M_LRU;
            end
            S_M_LRU: begin
                w_cmd   = CMD_LRU_SCAN;
                n_state = S_M_OUT;
            end
            S_M_OUT: begin
                if (i_st.out_free) begin
                    w_cmd   = CMD_OUT_MISS;
                    n_state = S_IDLE;
                end
            end
            S_FULL_OUT: begin
                if (i_st.out_free) begin
                    w_cmd   = CMD_OUT_FULL;
                    n_state = S_IDLE;
                end
            end
            S_MD_OUT: begin
                if (i_st.out_free) begin
                    w_cmd   = CMD_OUT_MD;
                    n_state = S_IDLE;
                end
            end
            S_FL_CHK: begin
                priority if (i_st.fl_end) begin
                    n_state = S_FL_DONE;
                end else if (i_st.fl_dirty) begin
                    n_state = S_FL_OUT;
                end else begin
                    w_cmd = CMD_FL_NEXT;
                end
            end
            S_FL_OUT: begin
                if (i_st.out_free) begin
                    w_cmd   = CMD_OUT_FL;
                    n_state = S_FL_CHK;
                end
            end
            S_FL_DONE: begin
                if (i_st.out_free) begin
                    w_cmd   = CMD_OUT_FLDONE;
                    n_state = S_IDLE;
                end
            end
            S_BAD_OUT: begin
                if (i_st.out_free) begin
                    w_cmd   = CMD_OUT_BAD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s_tready <= (n_state == S_IDLE);
        end
    end

    assign o_s_tready = r_s_tready && (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

`ifndef SYNTH
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> (w_cmd == CMD_LOAD))
        else $error("request accepted without capture");

    a_no_out_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_st.out_free) |-> (w_cmd != CMD_OUT_HIT && w_cmd != CMD_OUT_MISS
                              && w_cmd != CMD_OUT_FL && w_cmd != CMD_OUT_MD))
        else $error("result issued while result register is full");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready stayed high after a request was taken");
`endif

endmodule

>>> sv/block_cache_lru_hash_controller.sv
// ----------------------------------------------------------------------------
// block_cache_lru_hash_controller
// tag and replacement controller for a disk block cache with a linear
// probing hash and lru recency ranks
// a hit walks the probe chain, promotes the buffer and finds the new lru;
//   a miss also deletes the victim's entry by backward shift and probes for
//   a free slot; flush reports the dirty buffers up to the first invalid one
// one request in flight; the next request is taken while a result waits
// synchronous active low reset clears all flags at once, no clearing pass
// ----------------------------------------------------------------------------
module block_cache_lru_hash_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // device[2:0], block_sector[34:3], target_slot[39:35]
    input  logic [bclh_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // status[0], slot[5:1], hit[6], read_needed[7], writeback_needed[8],
    // wb_device[11:9], wb_sector[43:12]
    output logic [bclh_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import bclh_pkg::*;

    t_cmd       w_cmd;
    t_dp_status w_st;

    bclh_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    bclh_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
